### rtl/g6ced_pkg.sv
// Shared types and constants for the graph6 cubic edge decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package g6ced_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VERT_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VERT_W + 1;
   localparam int ORDER_W      = 18;

   localparam logic [7:0]         PREFIX_CHAR  = 8'd126;
   localparam logic [7:0]         CHAR_BIAS    = 8'd63;
   localparam logic [ORDER_W-1:0] ORDER_LIMIT  = 18'd258047;
   localparam logic [2:0]         DEGREE_CUBIC = 3'd3;
   localparam logic [2:0]         DEGREE_SAT   = 3'd4;
   localparam logic [2:0]         LAST_BIT     = 3'd5;

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] STS_OK           = 3'd0;
   localparam logic [2:0] STS_UNSUP_HDR    = 3'd1;
   localparam logic [2:0] STS_BAD_HDR_CHAR = 3'd2;
   localparam logic [2:0] STS_BAD_ORDER    = 3'd3;
   localparam logic [2:0] STS_BAD_CHAR     = 3'd4;
   localparam logic [2:0] STS_SHORT        = 3'd5;
   localparam logic [2:0] STS_NOT_CUBIC    = 3'd6;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_record;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  left_vertex;
      logic [9:0]  right_vertex;
      logic [10:0] edge_index;
      logic [10:0] vertex_total;
      logic [2:0]  status;
      logic        last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_PREFIX,
      PH_ONE_GOOD,
      PH_TWO_GOOD,
      PH_ONE_BAD,
      PH_TWO_BAD,
      PH_DATA,
      PH_FAILED
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LATCH,
      OP_DECODE,
      OP_EDGE,
      OP_UPD_ROW,
      OP_UPD_COL,
      OP_SKIP,
      OP_END_CHK,
      OP_WALK,
      OP_STATUS,
      OP_FLUSH
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_BIT,
      ST_ROW,
      ST_COL,
      ST_FINISH,
      ST_ENDCHK,
      ST_WALK,
      ST_STATUS,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic go_bits;
      logic pairs_done;
      logic cur_bit;
      logic bit_last;
      logic end_flag;
      logic pend_valid;
      logic out_free;
      logic walk_done;
      logic clr_done;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/graph6_cubic_edge_decoder_core.sv
// Top level of the graph6 cubic edge decoder.
// Uses g6ced_pkg, g6ced_ctrl (sequencer) and g6ced_dpath (datapath).
//
//   channel  | ports                         | moves
//   ---------+-------------------------------+----------------------------------
//   request  | req_valid, req_stall, req_item| one record character + end flag
//   response | rsp_valid, rsp_stall, rsp_item| edge item or end-of-record status
//
// Flow: one item at a time; req_stall is low only while idle. An item passes
// through accept, decode, finish and flush, plus a skip step per clear bit and
// edge, row and column steps per set bit (read/modify/write of both endpoint
// degrees on the degree memory) and a step if the triangle runs out before the
// sixth bit; a header character goes straight from decode to finish. An end of
// record adds an end check, a read-and-clear walk of the degree memory that
// also does the cubic check, and a status step.
// Reset: a clearing pass over all 1024 degree memory entries; no item is taken
// during it. Results are held back one deep so the last flag can be set; with
// a full holdback and a full, stalled output register, the sequencer waits.
`default_nettype none

module graph6_cubic_edge_decoder_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  g6ced_pkg::req_item_type  req_item,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output g6ced_pkg::rsp_item_type  rsp_item
);
   import g6ced_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: walks bits, edges, end-of-record check
   g6ced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // header decode, triangle position, degree memory, result registers
   g6ced_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

### rtl/g6ced_ctrl.sv
// Sequencer for the graph6 cubic edge decoder.
// Depends on g6ced_pkg; drives the datapath by command, reads its status.
`default_nettype none

module g6ced_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  g6ced_pkg::dp_stat_type  stat,
   output g6ced_pkg::dp_cmd_type   cmd
);
   import g6ced_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.op   = OP_DECODE;
            state_in = stat.go_bits ? ST_BIT : ST_FINISH;
         end
         ST_BIT: begin
            if (stat.pairs_done) begin
               state_in = ST_FINISH;
            end else if (stat.cur_bit) begin
               if (!stat.pend_valid || stat.out_free) begin
                  cmd.op   = OP_EDGE;
                  state_in = ST_ROW;
               end
            end else begin
               cmd.op   = OP_SKIP;
               state_in = stat.bit_last ? ST_FINISH : ST_BIT;
            end
         end
         ST_ROW: begin
            cmd.op   = OP_UPD_ROW;
            state_in = ST_COL;
         end
         ST_COL: begin
            cmd.op   = OP_UPD_COL;
            state_in = stat.bit_last ? ST_FINISH : ST_BIT;
         end
         ST_FINISH: begin
            state_in = stat.end_flag ? ST_ENDCHK : ST_FLUSH;
         end
         ST_ENDCHK: begin
            cmd.op   = OP_END_CHK;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.op = OP_WALK;
            if (stat.walk_done) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (!stat.pend_valid || stat.out_free) begin
               cmd.op   = OP_STATUS;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/g6ced_dpath.sv
// Datapath of the graph6 cubic edge decoder: header decode, triangle walk,
// degree memory, one-result holdback and the output register. Uses g6ced_pkg.
`default_nettype none

module g6ced_dpath (
   input  wire                      clock,
   input  wire                      reset,
   input  g6ced_pkg::req_item_type  req_item,
   input  wire                      rsp_stall,
   output logic                     rsp_valid,
   output g6ced_pkg::rsp_item_type  rsp_item,
   input  g6ced_pkg::dp_cmd_type    cmd,
   output g6ced_pkg::dp_stat_type   stat
);
   import g6ced_pkg::*;

   // record state
   phase_type          phase_ff, phase_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [VERT_W-1:0]  col_ff, col_in;
   logic [VERT_W-1:0]  row_ff, row_in;
   logic               pairs_done_ff, pairs_done_in;
   logic [CNT_W-1:0]   edge_cnt_ff, edge_cnt_in;
   logic [2:0]         err_ff, err_in;

   // per-item latches
   logic [7:0]         char_ff, char_in;
   logic               end_ff, end_in;
   logic [2:0]         bit_idx_ff, bit_idx_in;

   // sweep / walk
   logic [CNT_W-1:0]   walk_ctr_ff, walk_ctr_in;
   logic               rd_pend_ff, rd_pend_in;

   // holdback and output
   logic               pend_valid_ff, pend_valid_in;
   rsp_item_type       pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // degree memory
   logic [2:0]         deg_mem_ff [MAX_VERTICES];
   logic [2:0]         deg_rd_ff;
   logic               mem_we, mem_re;
   logic [VERT_W-1:0]  mem_waddr, mem_raddr;
   logic [2:0]         mem_wdata;

   logic               good;
   logic [7:0]         bias_diff;
   logic [5:0]         char_val;
   logic [ORDER_W-1:0] order_shift;
   logic               row_wrap, col_last;
   logic [2:0]         deg_inc;
   logic [CNT_W-1:0]   walk_limit;
   logic               out_free;
   rsp_item_type       edge_item, status_item;

   function automatic logic order_ok(input logic [ORDER_W-1:0] o);
      order_ok = (o <= ORDER_LIMIT) && (o <= ORDER_W'(MAX_VERTICES));
   endfunction

   assign good        = (char_ff >= CHAR_BIAS) && (char_ff <= PREFIX_CHAR);
   assign bias_diff   = char_ff - CHAR_BIAS;
   assign char_val    = good ? bias_diff[5:0] : 6'd0;
   assign order_shift = {order_ff[ORDER_W-7:0], char_val};
   assign row_wrap    = ({1'b0, row_ff} + CNT_W'(1)) >= {1'b0, col_ff};
   assign col_last    = ({{(ORDER_W-VERT_W){1'b0}}, col_ff} + ORDER_W'(1)) >= order_ff;
   assign deg_inc     = (deg_rd_ff < DEGREE_SAT) ? deg_rd_ff + 3'd1 : deg_rd_ff;
   assign walk_limit  = (phase_ff == PH_DATA) ? order_ff[CNT_W-1:0] : '0;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      edge_item              = '0;
      edge_item.kind         = KIND_EDGE;
      edge_item.left_vertex  = row_ff;
      edge_item.right_vertex = col_ff;
      edge_item.edge_index   = edge_cnt_ff;
      status_item            = '0;
      status_item.kind       = KIND_STATUS;
      status_item.edge_index = edge_cnt_ff;
      status_item.vertex_total = walk_limit;
      status_item.status     = err_ff;
   end

   always_comb begin
      stat.go_bits    = (err_ff == STS_OK) && (phase_ff == PH_DATA) && good;
      stat.pairs_done = pairs_done_ff;
      stat.cur_bit    = char_val[bit_idx_ff];
      stat.bit_last   = (bit_idx_ff == 3'd0);
      stat.end_flag   = end_ff;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
      stat.walk_done  = !rd_pend_ff && (walk_ctr_ff >= walk_limit);
      stat.clr_done   = (walk_ctr_ff[VERT_W-1:0] == {VERT_W{1'b1}});
   end

   always_comb begin
      phase_in      = phase_ff;
      order_in      = order_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pairs_done_in = pairs_done_ff;
      edge_cnt_in   = edge_cnt_ff;
      err_in        = err_ff;
      char_in       = char_ff;
      end_in        = end_ff;
      bit_idx_in    = bit_idx_ff;
      walk_ctr_in   = walk_ctr_ff;
      rd_pend_in    = rd_pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = row_ff;
      mem_raddr     = row_ff;
      mem_wdata     = deg_inc;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = walk_ctr_ff[VERT_W-1:0];
            mem_wdata   = '0;
            walk_ctr_in = walk_ctr_ff + CNT_W'(1);
         end
         OP_LATCH: begin
            char_in    = req_item.char_byte;
            end_in     = req_item.end_of_record;
            bit_idx_in = LAST_BIT;
         end
         OP_DECODE: begin
            if (err_ff == STS_OK) begin
               unique case (phase_ff)
                  PH_START: begin
                     if (char_ff == PREFIX_CHAR) begin
                        phase_in = PH_PREFIX;
                     end else if (!good) begin
                        err_in   = STS_BAD_ORDER;
                        phase_in = PH_FAILED;
                     end else begin
                        order_in = {{(ORDER_W-6){1'b0}}, char_val};
                        if (!order_ok({{(ORDER_W-6){1'b0}}, char_val})) begin
                           err_in   = STS_BAD_ORDER;
                           phase_in = PH_FAILED;
                        end else begin
                           phase_in      = PH_DATA;
                           col_in        = VERT_W'(1);
                           row_in        = '0;
                           pairs_done_in = (char_val <= 6'd1);
                        end
                     end
                  end
                  PH_PREFIX: begin
                     if (char_ff == PREFIX_CHAR) begin
                        err_in   = STS_UNSUP_HDR;
                        phase_in = PH_FAILED;
                     end else begin
                        order_in = {{(ORDER_W-6){1'b0}}, char_val};
                        phase_in = good ? PH_ONE_GOOD : PH_ONE_BAD;
                     end
                  end
                  PH_ONE_GOOD, PH_ONE_BAD: begin
                     order_in = order_shift;
                     phase_in = (phase_ff == PH_ONE_GOOD && good) ? PH_TWO_GOOD
                                                                   : PH_TWO_BAD;
                  end
                  PH_TWO_GOOD, PH_TWO_BAD: begin
                     order_in = order_shift;
                     if (phase_ff == PH_TWO_BAD || !good) begin
                        err_in   = STS_BAD_HDR_CHAR;
                        phase_in = PH_FAILED;
                     end else if (!order_ok(order_shift)) begin
                        err_in   = STS_BAD_ORDER;
                        phase_in = PH_FAILED;
                     end else begin
                        phase_in      = PH_DATA;
                        col_in        = VERT_W'(1);
                        row_in        = '0;
                        pairs_done_in = (order_shift <= ORDER_W'(1));
                     end
                  end
                  PH_DATA: begin
                     if (!good) begin
                        err_in = STS_BAD_CHAR;
                     end
                  end
                  PH_FAILED: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_EDGE: begin
            if (pend_valid_ff) begin
               rsp_item_in      = pend_ff;
               rsp_item_in.last = 1'b0;
               rsp_valid_in     = 1'b1;
            end
            pend_in       = edge_item;
            pend_valid_in = 1'b1;
            edge_cnt_in   = edge_cnt_ff + CNT_W'(1);
            mem_re        = 1'b1;
            mem_raddr     = row_ff;
         end
         OP_UPD_ROW: begin
            mem_we    = 1'b1;
            mem_waddr = row_ff;
            mem_re    = 1'b1;
            mem_raddr = col_ff;
         end
         OP_UPD_COL, OP_SKIP: begin
            if (cmd.op == OP_UPD_COL) begin
               mem_we    = 1'b1;
               mem_waddr = col_ff;
            end
            bit_idx_in = bit_idx_ff - 3'd1;
            if (row_wrap) begin
               row_in = '0;
               if (col_last) begin
                  pairs_done_in = 1'b1;
               end else begin
                  col_in = col_ff + VERT_W'(1);
               end
            end else begin
               row_in = row_ff + VERT_W'(1);
            end
         end
         OP_END_CHK: begin
            if (err_ff == STS_OK) begin
               if (phase_ff == PH_PREFIX || phase_ff == PH_ONE_GOOD ||
                   phase_ff == PH_TWO_GOOD || phase_ff == PH_ONE_BAD ||
                   phase_ff == PH_TWO_BAD) begin
                  err_in = STS_UNSUP_HDR;
               end else if (!pairs_done_ff) begin
                  err_in = STS_SHORT;
               end
            end
            walk_ctr_in = '0;
            rd_pend_in  = 1'b0;
         end
         OP_WALK: begin
            // read-and-clear sweep; data of the previous address checked here
            if (rd_pend_ff && deg_rd_ff != DEGREE_CUBIC && err_ff == STS_OK) begin
               err_in = STS_NOT_CUBIC;
            end
            if (walk_ctr_ff < walk_limit) begin
               mem_we      = 1'b1;
               mem_waddr   = walk_ctr_ff[VERT_W-1:0];
               mem_wdata   = '0;
               mem_re      = 1'b1;
               mem_raddr   = walk_ctr_ff[VERT_W-1:0];
               walk_ctr_in = walk_ctr_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
         end
         OP_STATUS: begin
            if (pend_valid_ff) begin
               rsp_item_in      = pend_ff;
               rsp_item_in.last = 1'b0;
               rsp_valid_in     = 1'b1;
            end
            pend_in       = status_item;
            pend_valid_in = 1'b1;
            // record done: back to start of record
            phase_in      = PH_START;
            order_in      = '0;
            col_in        = VERT_W'(1);
            row_in        = '0;
            pairs_done_in = 1'b0;
            edge_cnt_in   = '0;
            err_in        = STS_OK;
         end
         OP_FLUSH: begin
            rsp_item_in      = pend_ff;
            rsp_item_in.last = 1'b1;
            rsp_valid_in     = 1'b1;
            pend_valid_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         order_ff      <= '0;
         col_ff        <= VERT_W'(1);
         row_ff        <= '0;
         pairs_done_ff <= 1'b0;
         edge_cnt_ff   <= '0;
         err_ff        <= STS_OK;
         walk_ctr_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         order_ff      <= order_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pairs_done_ff <= pairs_done_in;
         edge_cnt_ff   <= edge_cnt_in;
         err_ff        <= err_in;
         walk_ctr_ff   <= walk_ctr_in;
         rd_pend_ff    <= rd_pend_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      end_ff      <= end_in;
      bit_idx_ff  <= bit_idx_in;
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deg_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         deg_rd_ff <= deg_mem_ff[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### tb/edge_stream_checker.sv
// Checker for the graph6 cubic edge decoder: watches both channels, predicts
// the edge and status items from each accepted character and compares them.
// Depends on g6ced_pkg for the item types, status codes and decoder phases.
`default_nettype none

module edge_stream_checker (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  g6ced_pkg::req_item_type  req_item,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  g6ced_pkg::rsp_item_type  rsp_item,
   output int                       mismatch_count,
   output int                       results_due
);
   import g6ced_pkg::*;

   // decoder state as the block should hold it
   phase_type     phase;
   logic [17:0]   order_acc;
   int unsigned   col_pos;
   int unsigned   row_pos;
   bit            all_pairs;
   logic [10:0]   edges_out;
   logic [2:0]    err_code;
   logic [2:0]    degree_of [MAX_VERTICES];

   rsp_item_type  items_due [$];
   rsp_item_type  want;
   int            errors;

   task automatic clear_decoder();
      int v;
      phase     = PH_START;
      order_acc = '0;
      col_pos   = 1;
      row_pos   = 0;
      all_pairs = 1'b0;
      edges_out = '0;
      err_code  = STS_OK;
      for (v = 0; v < MAX_VERTICES; v++) degree_of[v] = '0;
   endtask

   task automatic raise(input logic [2:0] code);
      if (err_code == STS_OK) err_code = code;
   endtask

   task automatic open_data();
      if (order_acc > ORDER_LIMIT || order_acc > MAX_VERTICES) begin
         raise(STS_BAD_ORDER);
         phase = PH_FAILED;
      end else begin
         phase     = PH_DATA;
         col_pos   = 1;
         row_pos   = 0;
         all_pairs = (order_acc <= 1);
      end
   endtask

   task automatic bump(input int unsigned v);
      if (v < MAX_VERTICES && degree_of[v] < DEGREE_SAT) degree_of[v] = degree_of[v] + 1'b1;
   endtask

   task automatic step_pair();
      row_pos++;
      if (row_pos >= col_pos) begin
         row_pos = 0;
         if (col_pos + 1 >= order_acc) all_pairs = 1'b1;
         else col_pos++;
      end
   endtask

   function automatic rsp_item_type make_result(input logic kind, input int unsigned lo,
                                                input int unsigned hi, input logic [10:0] idx,
                                                input logic [10:0] total,
                                                input logic [2:0] sts);
      rsp_item_type r;
      r.kind         = kind;
      r.left_vertex  = lo[9:0];
      r.right_vertex = hi[9:0];
      r.edge_index   = idx;
      r.vertex_total = total;
      r.status       = sts;
      r.last         = 1'b0;
      return r;
   endfunction

   // works out every item one character causes and queues them in order
   task automatic decode_char(input req_item_type it);
      rsp_item_type batch [$];
      logic [7:0]   c;
      bit           in_range;
      logic [5:0]   six;
      logic [10:0]  total;
      int           b;
      int unsigned  v;
      c        = it.char_byte;
      in_range = (c >= CHAR_BIAS) && (c <= PREFIX_CHAR);
      six      = in_range ? 6'(c - CHAR_BIAS) : 6'd0;
      total    = '0;
      if (err_code != STS_OK) begin
         // swallowed until the end flag
      end else begin
         case (phase)
            PH_START: begin
               if (c == PREFIX_CHAR) begin
                  phase = PH_PREFIX;
               end else if (!in_range) begin
                  raise(STS_BAD_ORDER);
                  phase = PH_FAILED;
               end else begin
                  order_acc = {12'd0, six};
                  open_data();
               end
            end
            PH_PREFIX: begin
               if (c == PREFIX_CHAR) begin
                  raise(STS_UNSUP_HDR);
                  phase = PH_FAILED;
               end else begin
                  order_acc = {12'd0, six};
                  phase = in_range ? PH_ONE_GOOD : PH_ONE_BAD;
               end
            end
            PH_ONE_GOOD, PH_ONE_BAD: begin
               order_acc = {order_acc[11:0], six};
               phase = (phase == PH_ONE_GOOD && in_range) ? PH_TWO_GOOD : PH_TWO_BAD;
            end
            PH_TWO_GOOD, PH_TWO_BAD: begin
               order_acc = {order_acc[11:0], six};
               if (phase == PH_TWO_BAD || !in_range) begin
                  raise(STS_BAD_HDR_CHAR);
                  phase = PH_FAILED;
               end else begin
                  open_data();
               end
            end
            PH_DATA: begin
               if (!in_range) begin
                  raise(STS_BAD_CHAR);
               end else begin
                  for (b = 5; b >= 0; b--) begin
                     if (all_pairs) break;
                     if (six[b]) begin
                        batch.insert(batch.size(),
                                     make_result(KIND_EDGE, row_pos, col_pos,
                                                 edges_out, '0, STS_OK));
                        edges_out = edges_out + 1'b1;
                        bump(row_pos);
                        bump(col_pos);
                     end
                     step_pair();
                  end
               end
            end
            default: ;
         endcase
      end

      if (it.end_of_record) begin
         if (err_code == STS_OK && phase >= PH_PREFIX && phase <= PH_TWO_BAD)
            raise(STS_UNSUP_HDR);
         if (err_code == STS_OK) begin
            if (!all_pairs) begin
               raise(STS_SHORT);
            end else begin
               for (v = 0; v < order_acc && v < MAX_VERTICES; v++) begin
                  if (degree_of[v] != DEGREE_CUBIC) begin
                     raise(STS_NOT_CUBIC);
                     break;
                  end
               end
            end
         end
         if (phase == PH_DATA) total = order_acc[10:0];
         batch.insert(batch.size(),
                      make_result(KIND_STATUS, 0, 0, edges_out, total, err_code));
         clear_decoder();
      end

      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) items_due.insert(items_due.size(), batch[k]);
   endtask

   task automatic check_field(input string name, input logic [10:0] exp_v,
                              input logic [10:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s differs: expected %0d, got %0d", $time, name, exp_v, got_v);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      clear_decoder();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         items_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (items_due.size() == 0) begin
               $display("%0t: unexpected item: expected none, got kind %0d l %0d r %0d idx %0d total %0d st %0d",
                        $time, rsp_item.kind, rsp_item.left_vertex, rsp_item.right_vertex,
                        rsp_item.edge_index, rsp_item.vertex_total, rsp_item.status);
               errors++;
            end else begin
               want = items_due.pop_front();
               check_field("kind", 11'(want.kind), 11'(rsp_item.kind));
               check_field("left_vertex", 11'(want.left_vertex), 11'(rsp_item.left_vertex));
               check_field("right_vertex", 11'(want.right_vertex),
                           11'(rsp_item.right_vertex));
               check_field("edge_index", want.edge_index, rsp_item.edge_index);
               check_field("vertex_total", want.vertex_total, rsp_item.vertex_total);
               check_field("status", 11'(want.status), 11'(rsp_item.status));
               check_field("last", 11'(want.last), 11'(rsp_item.last));
            end
         end
         if (req_valid && !req_stall) decode_char(req_item);
      end
      // registered so the top never samples these mid-update
      results_due    <= items_due.size();
      mismatch_count <= errors;
   end

   // anything still queued at the end is reported by the top via results_due

endmodule

`default_nettype wire

### tb/tb.sv
// Top of the graph6 cubic edge decoder testbench: clock, reset, character
// stimulus, result-side stalls and the final verdict.
// Depends on g6ced_pkg, graph6_cubic_edge_decoder_core and edge_stream_checker.
`default_nettype none

module tb;
   import g6ced_pkg::*;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_item_type  req_item  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_item_type  rsp_item;

   int            mismatch_count;
   int            results_due;

   // per-record switches: when set, that side never idles
   bit            quiet_req;
   bit            quiet_rsp;
   int            rsp_hold;
   int            fed_items;

   // characters of the record being built
   logic [7:0]    rec_q [$];

   graph6_cubic_edge_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   edge_stream_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop. The slowest legal run (every item at full gap, every result
   // at full stall, a 1024-vertex walk per long record, the reset clearing
   // pass) stays well below this.
   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: after each accepted item hold stall high for a drawn number
   // of cycles, so stalls land on edges, statuses and back-to-back bursts alike.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_hold = quiet_rsp ? 0 : $urandom_range(0, 17);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One character. Valid only drops when a gap is drawn, so a zero gap keeps
   // it high across items with a single assignment per step.
   task automatic send_char(input logic [7:0] c, input logic eor);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item.char_byte     <= c;
      req_item.end_of_record <= eor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fed_items++;
   endtask

   // Sends rec_q with the end flag on its last character, then empties it.
   task automatic send_record();
      int k;
      quiet_req = ($urandom_range(0, 4) == 0);
      quiet_rsp = ($urandom_range(0, 4) == 0);
      for (k = 0; k < rec_q.size(); k++) send_char(rec_q[k], k == rec_q.size() - 1);
      rec_q.delete();
   endtask

   // appends one character to the record being built
   task automatic add_char(input logic [7:0] c);
      rec_q.insert(rec_q.size(), c);
   endtask

   // Order header: one character up to 62 unless long_form is set, else the prefix and three sextets.
   task automatic put_header(input int unsigned n, input bit long_form);
      if (!long_form && n <= 62) begin
         add_char(8'(n) + CHAR_BIAS);
      end else begin
         add_char(PREFIX_CHAR);
         add_char(8'((n >> 12) & 63) + CHAR_BIAS);
         add_char(8'((n >> 6) & 63) + CHAR_BIAS);
         add_char(8'(n & 63) + CHAR_BIAS);
      end
   endtask

   // Upper triangle in column order. shape 0: cubic ladder (cycle plus
   // antipodal chords, cubic for even n >= 4), 1: ladder with one bit flipped,
   // 2: random at a random density, 3: complete graph. Pad bits are random.
   task automatic put_triangle(input int unsigned n, input int shape);
      bit          bits [$];
      int unsigned i, j, d;
      int          density, k, b;
      logic [5:0]  six;
      density = $urandom_range(0, 100);
      for (j = 1; j < n; j++) begin
         for (i = 0; i < j; i++) begin
            d = j - i;
            case (shape)
               0, 1:    bits.insert(bits.size(), d == 1 || d == n - 1 || d == n / 2);
               2:       bits.insert(bits.size(), $urandom_range(0, 99) < density);
               default: bits.insert(bits.size(), 1'b1);
            endcase
         end
      end
      if (shape == 1 && bits.size() > 0) begin
         k = $urandom_range(0, bits.size() - 1);
         bits[k] = !bits[k];
      end
      k = 0;
      while (k < bits.size()) begin
         for (b = 5; b >= 0; b--) begin
            six[b] = (k < bits.size()) ? bits[k] : 1'($urandom_range(0, 1));
            k++;
         end
         add_char({2'b00, six} + CHAR_BIAS);
      end
   endtask

   // any byte the decoder treats as outside the character range
   function automatic logic [7:0] stray_byte();
      return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 62))
                                         : 8'($urandom_range(127, 255));
   endfunction

   function automatic logic [7:0] good_byte();
      return 8'($urandom_range(63, 126));
   endfunction

   initial begin
      int          pick, hdr_len, cut, k, sub;
      int unsigned n;

      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
      fed_items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed records ----
      rec_q = '{"?"};                       // order 0: ok, no edges
      send_record();
      rec_q = '{"@"};                       // order 1: a lone vertex is not cubic
      send_record();
      rec_q = '{"C", "~"};                  // K4: an edge on every pair, then ok
      send_record();
      rec_q = '{PREFIX_CHAR, PREFIX_CHAR};  // prefix given twice
      send_record();
      rec_q = '{PREFIX_CHAR, "A"};          // record ends inside the long header
      send_record();
      rec_q = '{PREFIX_CHAR, 8'h20, "A", "A"};  // bad first header character
      send_record();
      rec_q = '{8'hFF};                     // one-character header out of range
      send_record();
      rec_q = '{PREFIX_CHAR, "?", "O", "@"};    // order 1025, above the vertex limit
      send_record();
      rec_q = '{PREFIX_CHAR, "?", "O", "?"};    // order 1024, ends at once: short
      send_record();
      rec_q = '{"C", 8'h00, "~"};           // bad data character wins, rest ignored
      send_record();

      // ---- random records ----
      while (fed_items < 160) begin
         pick    = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) n = $urandom_range(13, 40);
         else n = $urandom_range(0, 12);
         if (pick < 35) begin
            // well formed, mostly cubic ladders
            n = ($urandom_range(0, 7) == 0) ? 2 * $urandom_range(7, 20)
                                             : 2 * $urandom_range(2, 8);
            put_header(n, $urandom_range(0, 3) == 0);
            put_triangle(n, ($urandom_range(0, 3) == 0) ? 1 : 0);
         end else if (pick < 50) begin
            put_header(n, $urandom_range(0, 3) == 0);
            put_triangle(n, 2);
         end else if (pick < 64) begin
            // truncated triangle, or extra characters past the triangle
            put_header(n, $urandom_range(0, 3) == 0);
            hdr_len = rec_q.size();
            put_triangle(n, $urandom_range(0, 2));
            if (pick < 57 && rec_q.size() > hdr_len) begin
               cut = $urandom_range(1, rec_q.size() - hdr_len);
               repeat (cut) void'(rec_q.pop_back());
            end else begin
               repeat ($urandom_range(1, 3))
                  add_char(($urandom_range(0, 3) == 0) ? stray_byte() : good_byte());
            end
         end else if (pick < 74) begin
            // out-of-range character somewhere in the data
            put_header(n, $urandom_range(0, 3) == 0);
            hdr_len = rec_q.size();
            put_triangle(n, $urandom_range(0, 2));
            k = $urandom_range(hdr_len, rec_q.size());
            rec_q.insert(k, stray_byte());
         end else if (pick < 86) begin
            // header faults
            sub = $urandom_range(0, 3);
            case (sub)
               0: begin
                  rec_q = '{PREFIX_CHAR, PREFIX_CHAR};
                  repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
               end
               1: begin
                  rec_q = '{PREFIX_CHAR};
                  repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 125)));
               end
               2: begin
                  rec_q = '{PREFIX_CHAR, good_byte(), good_byte(), good_byte()};
                  if (rec_q[1] == PREFIX_CHAR) rec_q[1] = "A";
                  rec_q[$urandom_range(1, 3)] = stray_byte();
                  if ($urandom_range(0, 1) == 0) rec_q[$urandom_range(1, 3)] = stray_byte();
                  if (rec_q[1] == PREFIX_CHAR) rec_q[1] = 8'h00;
                  repeat ($urandom_range(0, 2)) add_char(good_byte());
               end
               default: begin
                  rec_q = '{stray_byte()};
                  repeat ($urandom_range(0, 2)) add_char(good_byte());
               end
            endcase
         end else if (pick < 94) begin
            // noise
            repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
         end else begin
            // long header with a large order; only a few data characters follow
            if ($urandom_range(0, 2) == 0) n = $urandom_range(1025, 258047);
            else n = $urandom_range(41, 1024);
            put_header(n, 1'b1);
            repeat ($urandom_range(0, 4))
               add_char(($urandom_range(0, 5) == 0) ? stray_byte() : good_byte());
         end
         send_record();
      end

      // ---- drain ----
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      // the last item is always an end of record, so its status is the final
      // result; a short wait catches anything stray behind it
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
